@@ design/tccw_pkg.sv @@
// Shared types and constants for the text console character writer.
package tccw_pkg;

   // Cell and character codes
   localparam logic [15:0] BLANK_CELL = 16'h0700;
   localparam logic [7:0]  CH_BELL    = 8'd7;
   localparam logic [7:0]  CH_BS      = 8'd8;
   localparam logic [7:0]  CH_LF      = 8'd10;
   localparam logic [7:0]  CH_CR      = 8'd13;
   localparam logic [7:0]  CH_SPACE   = 8'h20;

   // Request commands
   localparam logic CMD_PUT  = 1'b0;
   localparam logic CMD_READ = 1'b1;

   // Command queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;

   typedef struct packed {
      logic       cmd;
      logic [7:0] char_code;
      logic [7:0] attr_byte;
      logic [4:0] read_row;
      logic [6:0] read_col;
   } req_type;

   typedef struct packed {
      logic [4:0]  cursor_row;
      logic [6:0]  cursor_col;
      logic        bell;
      logic        scrolled;
      logic [15:0] cell_data;
   } rsp_type;

   typedef enum logic [2:0] {
      K_PUT  = 3'd0,
      K_CR   = 3'd1,
      K_LF   = 3'd2,
      K_BS   = 3'd3,
      K_BELL = 3'd4,
      K_READ = 3'd5
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] char_code;
      logic [7:0] attr_byte;
      logic [4:0] read_row;
      logic [6:0] read_col;
      logic       read_ok;
   } entry_type;

endpackage

@@ design/tccw_front.sv @@
// Front end: accepts request beats and classifies them into queue entries.
module tccw_front import tccw_pkg::*; #(
   parameter int SCREEN_COLS = 80,
   parameter int SCREEN_ROWS = 25
) (
   input  logic      req_valid,
   output logic      req_stall,
   input  req_type   req_data,
   input  logic      q_full,
   input  logic      clearing,
   output logic      push,
   output entry_type push_entry
);

   kind_type kind;

   always_comb begin
      if (req_data.cmd == CMD_READ) begin
         kind = K_READ;
      end else begin
         case (req_data.char_code)
            CH_CR:   kind = K_CR;
            CH_LF:   kind = K_LF;
            CH_BS:   kind = K_BS;
            CH_BELL: kind = K_BELL;
            default: kind = K_PUT;
         endcase
      end
   end

   assign req_stall = q_full || clearing;
   assign push      = req_valid && !req_stall;

   assign push_entry.kind      = kind;
   assign push_entry.char_code = req_data.char_code;
   assign push_entry.attr_byte = req_data.attr_byte;
   assign push_entry.read_row  = req_data.read_row;
   assign push_entry.read_col  = req_data.read_col;
   // out-of-screen reads return zero
   assign push_entry.read_ok   = (9'(req_data.read_row) < 9'(SCREEN_ROWS)) &&
                                 (9'(req_data.read_col) < 9'(SCREEN_COLS));

endmodule

@@ design/tccw_queue.sv @@
// Short command queue between the front and back ends.
module tccw_queue import tccw_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   input  logic      pop,
   output logic      full,
   output logic      empty,
   output entry_type head
);

   entry_type            entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]      count_ff, count_in;

   assign full  = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

@@ design/tccw_back.sv @@
// Back end: cursor, screen memory with row rotation, scroll fill and result register.
module tccw_back import tccw_pkg::*; #(
   parameter int SCREEN_COLS = 80,
   parameter int SCREEN_ROWS = 25
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      q_empty,
   input  entry_type head,
   output logic      pop,
   output logic      clearing,
   output logic      rsp_valid,
   input  logic      rsp_stall,
   output rsp_type   rsp_data
);

   localparam int CELLS  = SCREEN_ROWS * SCREEN_COLS;
   localparam int ROW_W  = (SCREEN_ROWS > 1) ? $clog2(SCREEN_ROWS) : 1;
   localparam int COL_W  = (SCREEN_COLS > 1) ? $clog2(SCREEN_COLS) : 1;
   localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(SCREEN_ROWS - 1);
   localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(SCREEN_COLS - 1);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CELLS - 1);
   localparam logic [ROW_W:0]    ROWS_EXT  = (ROW_W+1)'(SCREEN_ROWS);

   typedef enum logic [3:0] {
      ST_CLEAR = 4'b0001,
      ST_RUN   = 4'b0010,
      ST_RDATA = 4'b0100,
      ST_FILL  = 4'b1000
   } state_type;

   // logical row to physical row through the rotating top pointer
   function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] top,
                                                 input logic [ROW_W-1:0] r);
      logic [ROW_W:0] s;
      s = {1'b0, top} + {1'b0, r};
      if (s >= ROWS_EXT) begin
         s = s - ROWS_EXT;
      end
      return s[ROW_W-1:0];
   endfunction

   function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] prow,
                                                   input logic [COL_W-1:0] col);
      logic [ADDR_W:0] a;
      a = (ADDR_W+1)'(prow) * (ADDR_W+1)'(SCREEN_COLS) + (ADDR_W+1)'(col);
      return a[ADDR_W-1:0];
   endfunction

   logic [15:0]       screen_mem [CELLS];
   logic [15:0]       rd_data_ff;

   state_type         state_ff, state_in;
   logic [ROW_W-1:0]  cur_row_ff, cur_row_in;
   logic [COL_W-1:0]  cur_col_ff, cur_col_in;
   logic [ROW_W-1:0]  top_ff, top_in;
   logic [ROW_W-1:0]  fill_row_ff, fill_row_in;
   logic [COL_W-1:0]  fill_col_ff, fill_col_in;
   logic [7:0]        fill_attr_ff, fill_attr_in;
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;
   logic              read_ok_ff, read_ok_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   logic              out_free;
   logic              rsp_load;
   logic              bell;
   logic              scroll;
   logic [15:0]       cell_word;
   logic              wr_en;
   logic              wr_use_clr;
   logic [ROW_W-1:0]  wr_prow;
   logic [COL_W-1:0]  wr_col;
   logic [15:0]       wr_data;
   logic [ADDR_W-1:0] wr_addr;
   logic [ROW_W-1:0]  rd_row;
   logic [COL_W-1:0]  rd_col;
   logic [ADDR_W-1:0] rd_addr;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign clearing  = (state_ff == ST_CLEAR);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign rd_row  = head.read_ok ? ROW_W'(head.read_row) : '0;
   assign rd_col  = head.read_ok ? COL_W'(head.read_col) : '0;
   assign rd_addr = cell_addr(phys_row(top_ff, rd_row), rd_col);
   assign wr_addr = wr_use_clr ? clr_addr_ff : cell_addr(wr_prow, wr_col);

   always_comb begin
      state_in     = state_ff;
      cur_row_in   = cur_row_ff;
      cur_col_in   = cur_col_ff;
      top_in       = top_ff;
      fill_row_in  = fill_row_ff;
      fill_col_in  = fill_col_ff;
      fill_attr_in = fill_attr_ff;
      clr_addr_in  = clr_addr_ff;
      read_ok_in   = read_ok_ff;
      pop          = 1'b0;
      rsp_load     = 1'b0;
      bell         = 1'b0;
      scroll       = 1'b0;
      cell_word    = '0;
      wr_en        = 1'b0;
      wr_use_clr   = 1'b0;
      wr_prow      = phys_row(top_ff, cur_row_ff);
      wr_col       = cur_col_ff;
      wr_data      = BLANK_CELL;

      case (state_ff)
         ST_CLEAR: begin
            wr_en      = 1'b1;
            wr_use_clr = 1'b1;
            if (clr_addr_ff == LAST_ADDR) begin
               state_in = ST_RUN;
            end else begin
               clr_addr_in = clr_addr_ff + 1'b1;
            end
         end
         ST_RUN: begin
            if (!q_empty && out_free) begin
               pop = 1'b1;
               case (head.kind)
                  K_READ: begin
                     read_ok_in = head.read_ok;
                     state_in   = ST_RDATA;
                  end
                  K_CR: begin
                     cur_col_in = '0;
                     rsp_load   = 1'b1;
                  end
                  K_LF: begin
                     rsp_load = 1'b1;
                     if (cur_row_ff == LAST_ROW) begin
                        scroll = 1'b1;
                     end else begin
                        cur_row_in = cur_row_ff + 1'b1;
                     end
                  end
                  K_BS: begin
                     rsp_load = 1'b1;
                     wr_en    = 1'b1;
                     if (cur_col_ff != '0) begin
                        cur_col_in = cur_col_ff - 1'b1;
                     end
                     wr_col = cur_col_in;
                  end
                  K_BELL: begin
                     bell     = 1'b1;
                     rsp_load = 1'b1;
                  end
                  default: begin
                     rsp_load = 1'b1;
                     wr_en    = 1'b1;
                     wr_data  = {head.attr_byte, head.char_code};
                     if (cur_col_ff == LAST_COL) begin
                        cur_col_in = '0;
                        if (cur_row_ff == LAST_ROW) begin
                           scroll = 1'b1;
                        end else begin
                           cur_row_in = cur_row_ff + 1'b1;
                        end
                     end else begin
                        cur_col_in = cur_col_ff + 1'b1;
                     end
                  end
               endcase
               if (scroll) begin
                  fill_row_in  = top_ff;
                  fill_col_in  = '0;
                  fill_attr_in = head.attr_byte;
                  top_in       = (top_ff == LAST_ROW) ? '0 : top_ff + 1'b1;
                  state_in     = ST_FILL;
               end
            end
         end
         ST_RDATA: begin
            rsp_load  = 1'b1;
            cell_word = read_ok_ff ? rd_data_ff : '0;
            state_in  = ST_RUN;
         end
         ST_FILL: begin
            wr_en   = 1'b1;
            wr_prow = fill_row_ff;
            wr_col  = fill_col_ff;
            wr_data = {fill_attr_ff, CH_SPACE};
            if (fill_col_ff == LAST_COL) begin
               state_in = ST_RUN;
            end else begin
               fill_col_in = fill_col_ff + 1'b1;
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase

      rsp_data_in.cursor_row = 5'(cur_row_in);
      rsp_data_in.cursor_col = 7'(cur_col_in);
      rsp_data_in.bell       = bell;
      rsp_data_in.scrolled   = scroll;
      rsp_data_in.cell_data  = cell_word;

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cur_row_ff   <= '0;
         cur_col_ff   <= '0;
         top_ff       <= '0;
         fill_row_ff  <= '0;
         fill_col_ff  <= '0;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_row_ff   <= cur_row_in;
         cur_col_ff   <= cur_col_in;
         top_ff       <= top_in;
         fill_row_ff  <= fill_row_in;
         fill_col_ff  <= fill_col_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fill_attr_ff <= fill_attr_in;
      read_ok_ff   <= read_ok_in;
      if (rsp_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         screen_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= screen_mem[rd_addr];
   end

endmodule

@@ design/text_console_char_writer_core.sv @@
// Top level of the teletype-style text console character writer.
//
// A request beat either puts a character byte at the cursor (bytes other
// than CR/LF/BS/bell are stored with their attribute; CR, LF and BS move
// the cursor, BS also blanking the cell, and bell flags the response) or
// reads one screen cell; every request gives exactly one response beat
// with the cursor after the request. The screen is a single-port-write
// memory of SCREEN_ROWS x SCREEN_COLS 16-bit cells; scrolling rotates a
// top-row pointer instead of moving rows, then clears the freed row with
// spaces in the request's attribute at one cell per cycle. After reset
// the block sweeps every cell to 0x0700 with req_stall held high. A read
// passes through the ST_RDATA state to take the registered memory read;
// a request that scrolls is followed by the row clear. A two-entry
// command queue parts the accepting front end from the executing back
// end, and a response register lets the block take new request beats
// while a response beat waits on rsp_stall.
module text_console_char_writer_core import tccw_pkg::*; #(
   parameter int SCREEN_COLS = 80,
   parameter int SCREEN_ROWS = 25
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic      push;
   entry_type push_entry;
   logic      pop;
   logic      q_full;
   logic      q_empty;
   entry_type q_head;
   logic      clearing;

   // Classify request beats; hold them off while the queue is full or the
   // screen is still being cleared after reset.
   tccw_front #(
      .SCREEN_COLS (SCREEN_COLS),
      .SCREEN_ROWS (SCREEN_ROWS)
   ) u_front (
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .q_full     (q_full),
      .clearing   (clearing),
      .push       (push),
      .push_entry (push_entry)
   );

   // Buffer classified commands so each side stalls on its own.
   tccw_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (q_full),
      .empty      (q_empty),
      .head       (q_head)
   );

   // Execute commands: advance the cursor, write or read the screen, drop
   // into the row clear on a scroll and present the response beat.
   tccw_back #(
      .SCREEN_COLS (SCREEN_COLS),
      .SCREEN_ROWS (SCREEN_ROWS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .head      (q_head),
      .pop       (pop),
      .clearing  (clearing),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

@@ tb/tccw_screen_check.sv @@
// Screen predictor and response checker for the text console character writer.
module tccw_screen_check import tccw_pkg::*; #(
   parameter int COLS = 80,
   parameter int ROWS = 25
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_data,
   output int      failures,
   output int      outstanding
);

   logic [15:0] screen [ROWS*COLS];
   int unsigned row_now;
   int unsigned col_now;
   rsp_type     due_reports [$];
   rsp_type     want;
   int          mismatch_total = 0;

   function automatic void clear_screen();
      foreach (screen[i]) screen[i] = BLANK_CELL;
      row_now = 0;
      col_now = 0;
   endfunction

   // move down one row; returns 1 when the screen scrolled
   function automatic logic next_line(input logic [7:0] attr);
      row_now++;
      if (row_now < ROWS) return 1'b0;
      for (int i = 0; i < (ROWS - 1) * COLS; i++) screen[i] = screen[i + COLS];
      for (int c = 0; c < COLS; c++) screen[(ROWS - 1) * COLS + c] = {attr, CH_SPACE};
      row_now = ROWS - 1;
      return 1'b1;
   endfunction

   function automatic rsp_type apply_to_screen(input req_type rq);
      rsp_type r;
      r = '0;
      if (rq.cmd == CMD_READ) begin
         if (rq.read_row < ROWS && rq.read_col < COLS)
            r.cell_data = screen[rq.read_row * COLS + rq.read_col];
      end else if (rq.char_code == CH_CR) begin
         col_now = 0;
      end else if (rq.char_code == CH_LF) begin
         r.scrolled = next_line(rq.attr_byte);
      end else if (rq.char_code == CH_BS) begin
         if (col_now > 0) col_now--;
         screen[row_now * COLS + col_now] = BLANK_CELL;
      end else if (rq.char_code == CH_BELL) begin
         r.bell = 1'b1;
      end else begin
         screen[row_now * COLS + col_now] = {rq.attr_byte, rq.char_code};
         col_now++;
         if (col_now >= COLS) begin
            col_now = 0;
            r.scrolled = next_line(rq.attr_byte);
         end
      end
      r.cursor_row = row_now[4:0];
      r.cursor_col = col_now[6:0];
      return r;
   endfunction

   function automatic void check_field(input string name, input logic [15:0] exp_v,
                                       input logic [15:0] act_v);
      if (act_v !== exp_v) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
         mismatch_total++;
      end
   endfunction

   // Compare the response beat first: it can never belong to a request taken at the same edge.
   always @(posedge clock) begin
      if (reset) begin
         clear_screen();
         due_reports.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (due_reports.size() == 0) begin
               $error("response beat with no request outstanding");
               mismatch_total++;
            end else begin
               want = due_reports.pop_front();
               check_field("cursor_row", 16'(want.cursor_row), 16'(rsp_data.cursor_row));
               check_field("cursor_col", 16'(want.cursor_col), 16'(rsp_data.cursor_col));
               check_field("bell", 16'(want.bell), 16'(rsp_data.bell));
               check_field("scrolled", 16'(want.scrolled), 16'(rsp_data.scrolled));
               check_field("cell_data", want.cell_data, rsp_data.cell_data);
            end
         end
         if (req_valid && !req_stall) due_reports.push_back(apply_to_screen(req_data));
      end
      failures    <= mismatch_total;
      outstanding <= due_reports.size();
   end

endmodule

@@ tb/text_console_char_writer_core_tb.sv @@
// Stimulus and verdict for the text console character writer core.
module text_console_char_writer_core_tb;
   import tccw_pkg::*;

   localparam int COLS        = 80;
   localparam int ROWS        = 25;
   localparam int DIRECTED    = 16;
   localparam int PHASE_BEATS = 134;   // four phases give about 550 beats in all
   localparam int SETTLE      = 100;   // longer than a row clear after a scroll

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   req_type req_data  = '0;
   logic    rsp_stall = 1'b0;
   logic    req_stall;
   logic    rsp_valid;
   rsp_type rsp_data;

   int failures;
   int outstanding;
   int idle_pct   = 0;
   int stall_pct  = 0;
   int beats_sent = 0;

   text_console_char_writer_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   tccw_screen_check #(.COLS(COLS), .ROWS(ROWS)) screen_check (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .failures    (failures),
      .outstanding (outstanding)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Back-pressure on the response side, redrawn every cycle.
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   // Hard stop, far beyond the slowest legal run.
   initial begin
      #(8 * 1_000_000);
      $display("FAILURE");
      $finish;
   end

   // Pick a byte that is stored rather than acted on.
   function automatic logic [7:0] glyph();
      logic [7:0] c;
      do c = 8'($urandom_range(0, 255));
      while (c == CH_CR || c == CH_LF || c == CH_BS || c == CH_BELL);
      return c;
   endfunction

   // The unused read coordinates still toggle, so every bit sees both values.
   function automatic req_type put_beat(input logic [7:0] ch, input logic [7:0] attr);
      req_type b;
      b.cmd       = CMD_PUT;
      b.char_code = ch;
      b.attr_byte = attr;
      b.read_row  = 5'($urandom());
      b.read_col  = 7'($urandom());
      return b;
   endfunction

   function automatic req_type read_beat(input logic [4:0] row, input logic [6:0] col);
      req_type b;
      b.cmd       = CMD_READ;
      b.char_code = 8'($urandom());
      b.attr_byte = 8'($urandom());
      b.read_row  = row;
      b.read_col  = col;
      return b;
   endfunction

   // Present one beat and hold it until taken. Valid stays high afterwards so
   // back-to-back beats never drop it; an idle gap in the next call or a drain lowers it.
   task automatic send_beat(input req_type beat);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      beats_sent++;
   endtask

   // Stop sending and wait for every outstanding response beat.
   task automatic drain_responses();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // One random burst: mostly text the way a terminal sees it, with some noise.
   task automatic send_random_burst();
      int         pick;
      logic [7:0] attr;
      pick = $urandom_range(0, 99);
      attr = 8'($urandom_range(0, 255));
      if (pick < 35) begin
         // short line ended by CR LF
         repeat ($urandom_range(0, 10)) send_beat(put_beat(glyph(), attr));
         send_beat(put_beat(CH_CR, attr));
         send_beat(put_beat(CH_LF, attr));
      end else if (pick < 41) begin
         // line of about a screen width, often long enough to wrap past the last column
         repeat ($urandom_range(75, 85)) send_beat(put_beat(glyph(), attr));
         if ($urandom_range(0, 1) == 1) send_beat(put_beat(CH_LF, attr));
      end else if (pick < 56) begin
         // blank lines push the cursor to the bottom and force scrolls
         repeat ($urandom_range(1, 8)) send_beat(put_beat(CH_LF, attr));
      end else if (pick < 71) begin
         // cell reads, now and then outside the screen
         repeat ($urandom_range(1, 4)) begin
            if ($urandom_range(0, 9) == 0)
               send_beat(read_beat(5'($urandom_range(0, 31)), 7'($urandom_range(0, 127))));
            else
               send_beat(read_beat(5'($urandom_range(0, ROWS - 1)),
                                   7'($urandom_range(0, COLS - 1))));
         end
      end else if (pick < 83) begin
         // type, perhaps return to the margin, then back up over it
         repeat ($urandom_range(1, 3)) send_beat(put_beat(glyph(), attr));
         if ($urandom_range(0, 3) == 0) send_beat(put_beat(CH_CR, attr));
         repeat ($urandom_range(1, 4)) send_beat(put_beat(CH_BS, attr));
      end else if (pick < 88) begin
         send_beat(put_beat(CH_BELL, attr));
      end else begin
         // raw noise across every field
         send_beat(req_type'(29'($urandom())));
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed beats: blank screen, out-of-range reads, extremes and controls.
      send_beat(read_beat(5'd0, 7'd0));
      send_beat(read_beat(5'(ROWS - 1), 7'(COLS - 1)));
      send_beat(read_beat(5'd31, 7'd127));
      send_beat(read_beat(5'(ROWS), 7'd0));
      send_beat(read_beat(5'd0, 7'(COLS)));
      send_beat(put_beat(CH_BS, 8'hFF));      // backspace at the margin holds column 0
      send_beat(put_beat(8'h00, 8'h00));
      send_beat(put_beat(8'hFF, 8'hFF));
      send_beat(put_beat(8'h41, 8'h1E));
      send_beat(put_beat(CH_BS, 8'h5A));      // blank the cell just written
      send_beat(read_beat(5'd0, 7'd1));
      send_beat(read_beat(5'd0, 7'd2));
      send_beat(put_beat(CH_BELL, 8'h33));
      send_beat(put_beat(CH_CR, 8'h44));
      send_beat(put_beat(CH_LF, 8'h55));
      send_beat(read_beat(5'd0, 7'd0));

      // Random phases with differing idle patterns; drain between them.
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin
               idle_pct  = 0;
               stall_pct <= 0;
            end
            1: begin
               idle_pct  = 65;
               stall_pct <= 0;
            end
            2: begin
               idle_pct  = 0;
               stall_pct <= 65;
            end
            default: begin
               idle_pct  = 35;
               stall_pct <= 35;
            end
         endcase
         while (beats_sent < DIRECTED + (ph + 1) * PHASE_BEATS) send_random_burst();
         drain_responses();
      end

      // Watch a while longer for any stray response beat.
      repeat (SETTLE) @(posedge clock);
      if (failures == 0 && outstanding == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
